@@ hdl/chacha20_drng_top_macros.svh @@
// Assertion helpers for the ChaCha20 DRNG block.
`ifndef CHACHA20_DRNG_TOP_MACROS_SVH
`define CHACHA20_DRNG_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CDRNG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CDRNG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/cdrng_pkg.sv @@
// ============================================================================
// cdrng_pkg
// Shared types, constants and the ChaCha20 quarter round.
// ============================================================================
`timescale 1ns / 1ps

package cdrng_pkg;

    typedef logic [31:0] word_t;

    localparam int KEY_WORDS   = 8;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 20;
    localparam logic [6:0] BLOCK_BYTES = 7'd64;

    localparam word_t SIGMA0 = 32'h61707865;
    localparam word_t SIGMA1 = 32'h3320646e;
    localparam word_t SIGMA2 = 32'h79622d32;
    localparam word_t SIGMA3 = 32'h6b206574;

    // Returns {a, b, c, d} after one quarter round.
    function automatic logic [127:0] quarter_round(word_t a_in, word_t b_in,
                                                   word_t c_in, word_t d_in);
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        a = a_in;
        b = b_in;
        c = c_in;
        d = d_in;
        a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
        c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
        a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
        c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
        return {a, b, c, d};
    endfunction

endpackage

@@ hdl/cdrng_in_if.sv @@
// ============================================================================
// cdrng_in_if
// Request channel: seed bytes and generate requests.
// ============================================================================
`timescale 1ns / 1ps

interface cdrng_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] seed_byte;
    logic       seed_last;
    logic [6:0] byte_count;
    logic       request_last;

    modport source (output valid, operation, seed_byte, seed_last, byte_count,
                    request_last, input ready);
    modport sink (input valid, operation, seed_byte, seed_last, byte_count,
                  request_last, output ready);
endinterface

@@ hdl/cdrng_out_if.sv @@
// ============================================================================
// cdrng_out_if
// Result channel: keystream words.
// ============================================================================
`timescale 1ns / 1ps

interface cdrng_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] random_word;
    logic [3:0]  valid_bytes;
    logic        block_done;

    modport source (output valid, random_word, valid_bytes, block_done, input ready);
    modport sink (input valid, random_word, valid_bytes, block_done, output ready);
endinterface

@@ hdl/chacha20_drng_top.sv @@
// Generate request: accepted in idle, then 20 rounds, then the final add; words then go out
//   one per cycle unless the receiver stalls; a request end adds a key update (fresh block if needed).
// Seed byte: taken in idle; when it triggers a key update, a fresh block and the update follow.
// Throughput: one request at a time; the single round unit sets the pace.
// Reset (rst_n, async low): key, counter, nonce and seed position cleared, block idle.
// ============================================================================
// chacha20_drng_top
// ChaCha20 DRNG with iterative round unit, key update sequencer and word output.
// ============================================================================
`timescale 1ns / 1ps

`include "chacha20_drng_top_macros.svh"

module chacha20_drng_top (
    input  logic       clk,
    input  logic       rst_n,
    cdrng_in_if.sink   in_req,
    cdrng_out_if.source out_rsp
);
    import cdrng_pkg::*;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_FINAL = 3'd2;
    localparam logic [2:0] ST_OUT   = 3'd3;
    localparam logic [2:0] ST_REKEY = 3'd4;

    logic [2:0]  state_reg, state_next;
    word_t       key_reg [KEY_WORDS];
    word_t       key_next [KEY_WORDS];
    word_t       x_reg [BLOCK_WORDS];   // working state / finished block
    word_t       x_next [BLOCK_WORDS];
    word_t       bc_reg, bc_next;
    logic [95:0] nonce_reg, nonce_next;
    logic [4:0]  pos_reg, pos_next;     // next seed key byte
    logic [4:0]  cnt_reg, cnt_next;     // round count, or rekey word count
    logic [6:0]  rem_reg, rem_next;     // bytes still to send
    logic        gen_reg, gen_next;     // block goes to output
    logic        rlast_reg, rlast_next; // rekey after this block
    logic        fresh_reg, fresh_next; // rekey needs a fresh block
    logic        off_reg, off_next;     // rekey source at x[15] instead of x[0]

    word_t       init_s [BLOCK_WORDS];
    word_t       fin_s [BLOCK_WORDS];
    word_t       rnd_y [BLOCK_WORDS];
    word_t       rnd_z [BLOCK_WORDS];
    word_t       rnd_r [BLOCK_WORDS];
    logic [127:0] qr_out [4];
    logic        in_acc, out_acc, start_blk;
    logic [6:0]  nsat;
    logic [4:0]  used;
    word_t       rk_src;
    logic [63:0] byte_mask;

    assign in_acc  = in_req.valid && in_req.ready;
    assign out_acc = out_rsp.valid && out_rsp.ready;
    assign in_req.ready = (state_reg == ST_IDLE);

    // Output straight from the finished block; it only rotates on a handshake
    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            byte_mask[b*8 +: 8] = (rem_reg > 7'(b)) ? 8'hff : 8'h00;
        end
    end
    assign out_rsp.valid       = (state_reg == ST_OUT);
    assign out_rsp.random_word = {x_reg[1], x_reg[0]} & byte_mask;
    assign out_rsp.valid_bytes = (rem_reg >= 7'd8) ? 4'd8 : rem_reg[3:0];
    assign out_rsp.block_done  = (rem_reg <= 7'd8);

    // Shared round unit: column round on even counts, diagonal on odd
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            rnd_y[j] = x_reg[j];
            if (!cnt_reg[0])
            begin
                rnd_y[4+j]  = x_reg[4+j];
                rnd_y[8+j]  = x_reg[8+j];
                rnd_y[12+j] = x_reg[12+j];
            end
            else
            begin
                rnd_y[4+j]  = x_reg[4+((j+1)&3)];
                rnd_y[8+j]  = x_reg[8+((j+2)&3)];
                rnd_y[12+j] = x_reg[12+((j+3)&3)];
            end
            qr_out[j]   = quarter_round(rnd_y[j], rnd_y[4+j], rnd_y[8+j], rnd_y[12+j]);
            rnd_z[j]    = qr_out[j][127:96];
            rnd_z[4+j]  = qr_out[j][95:64];
            rnd_z[8+j]  = qr_out[j][63:32];
            rnd_z[12+j] = qr_out[j][31:0];
        end
        for (int j = 0; j < 4; j++)
        begin
            rnd_r[j] = rnd_z[j];
            if (!cnt_reg[0])
            begin
                rnd_r[4+j]  = rnd_z[4+j];
                rnd_r[8+j]  = rnd_z[8+j];
                rnd_r[12+j] = rnd_z[12+j];
            end
            else
            begin
                rnd_r[4+((j+1)&3)]  = rnd_z[4+j];
                rnd_r[8+((j+2)&3)]  = rnd_z[8+j];
                rnd_r[12+((j+3)&3)] = rnd_z[12+j];
            end
        end
    end

    // Block input words: from the updated key for a new block, held key for final add
    always_comb
    begin
        init_s[0] = SIGMA0; init_s[1] = SIGMA1; init_s[2] = SIGMA2; init_s[3] = SIGMA3;
        fin_s[0]  = SIGMA0; fin_s[1]  = SIGMA1; fin_s[2]  = SIGMA2; fin_s[3]  = SIGMA3;
        for (int i = 0; i < KEY_WORDS; i++)
        begin
            init_s[4+i] = key_next[i];
            fin_s[4+i]  = key_reg[i];
        end
        init_s[12] = bc_next;         fin_s[12] = bc_reg;
        init_s[13] = nonce_reg[31:0]; fin_s[13] = nonce_reg[31:0];
        init_s[14] = nonce_reg[63:32]; fin_s[14] = nonce_reg[63:32];
        init_s[15] = nonce_reg[95:64]; fin_s[15] = nonce_reg[95:64];
    end

    assign nsat   = (in_req.byte_count > BLOCK_BYTES) ? BLOCK_BYTES : in_req.byte_count;
    assign used   = 5'((nsat + 7'd3) >> 2);
    assign rk_src = off_reg ? x_reg[BLOCK_WORDS-1] : x_reg[0];

    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        x_next     = x_reg;
        bc_next    = bc_reg;
        nonce_next = nonce_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        gen_next   = gen_reg;
        rlast_next = rlast_reg;
        fresh_next = fresh_reg;
        off_next   = off_reg;
        start_blk  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (!in_req.operation)
                    begin
                        key_next[pos_reg[4:2]] = key_reg[pos_reg[4:2]] ^
                            (word_t'(in_req.seed_byte) << {pos_reg[1:0], 3'b000});
                        if (pos_reg == 5'd31 || in_req.seed_last)
                        begin
                            pos_next  = '0;
                            gen_next  = 1'b0;
                            off_next  = 1'b0;
                            start_blk = 1'b1;
                        end
                        else
                        begin
                            pos_next = pos_reg + 5'd1;
                        end
                    end
                    else if (nsat != 7'd0)
                    begin
                        gen_next   = 1'b1;
                        rem_next   = nsat;
                        rlast_next = in_req.request_last;
                        fresh_next = (used > 5'(KEY_WORDS));
                        off_next   = used[0];
                        start_blk  = 1'b1;
                    end
                    else if (in_req.request_last)
                    begin
                        // empty last block: key update from a fresh block
                        gen_next  = 1'b0;
                        off_next  = 1'b0;
                        start_blk = 1'b1;
                    end
                end
            end
            ST_ROUND:
            begin
                x_next   = rnd_r;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(ROUNDS - 1))
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                for (int i = 0; i < BLOCK_WORDS; i++)
                begin
                    x_next[i] = x_reg[i] + fin_s[i];
                end
                bc_next  = bc_reg + 32'd1;
                cnt_next = '0;
                state_next = gen_reg ? ST_OUT : ST_REKEY;
            end
            ST_OUT:
            begin
                if (out_acc)
                begin
                    for (int i = 0; i < BLOCK_WORDS; i++)
                    begin
                        x_next[i] = x_reg[(i+2) & (BLOCK_WORDS-1)];
                    end
                    rem_next = rem_reg - 7'd8;
                    if (rem_reg <= 7'd8)
                    begin
                        gen_next = 1'b0;
                        cnt_next = '0;
                        if (!rlast_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (fresh_reg)
                        begin
                            off_next  = 1'b0;
                            start_blk = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_REKEY;
                        end
                    end
                end
            end
            ST_REKEY:
            begin
                for (int i = 0; i < KEY_WORDS - 1; i++)
                begin
                    key_next[i] = key_reg[i+1];
                end
                key_next[KEY_WORDS-1] = key_reg[0] ^ rk_src;
                for (int i = 0; i < BLOCK_WORDS; i++)
                begin
                    x_next[i] = x_reg[(i+1) & (BLOCK_WORDS-1)];
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg[2:0] == 3'(KEY_WORDS - 1))
                begin
                    nonce_next = nonce_reg + 96'd1;
                    off_next   = 1'b0;
                    rlast_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (start_blk)
        begin
            x_next     = init_s;
            cnt_next   = '0;
            state_next = ST_ROUND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < KEY_WORDS; i++)
            begin
                key_reg[i] <= '0;
            end
            bc_reg    <= '0;
            nonce_reg <= '0;
            pos_reg   <= '0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            gen_reg   <= 1'b0;
            rlast_reg <= 1'b0;
            fresh_reg <= 1'b0;
            off_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
            bc_reg    <= bc_next;
            nonce_reg <= nonce_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            gen_reg   <= gen_next;
            rlast_reg <= rlast_next;
            fresh_reg <= fresh_next;
            off_reg   <= off_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
    end

    `CDRNG_ASSERT_IMP(a_ready_no_out, in_req.ready, !out_rsp.valid, "ready while results pending")
    `CDRNG_ASSERT_IMP(a_round_bound, state_reg == ST_ROUND, cnt_reg < 5'(ROUNDS), "round count overrun")
    `CDRNG_ASSERT_IMP(a_out_bytes, out_rsp.valid, rem_reg != 7'd0 && gen_reg, "output with no bytes left")
    `CDRNG_ASSERT_NXT(a_bc_step, state_reg == ST_FINAL, bc_reg == $past(bc_reg) + 32'd1, "block counter not advanced")

endmodule

@@ tb/tb_chacha20_drng_top.sv @@
// ============================================================================
// tb_chacha20_drng_top
// Self-checking bench for the ChaCha20 DRNG: seed and generate requests, with
// keystream words compared against an in-bench ChaCha20 state predictor.
// ============================================================================
`timescale 1ns / 1ps

module tb_chacha20_drng_top;
    import cdrng_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic       operation;
        logic [7:0] seed_byte;
        logic       seed_last;
        logic [6:0] byte_count;
        logic       request_last;
    } drng_req_t;

    typedef struct packed {
        logic [63:0] random_word;
        logic [3:0]  valid_bytes;
        logic        block_done;
    } drng_word_t;

    // One directed stimulus row; chk_first types in the first word when it
    // can be read off directly (only the very first block after reset).
    typedef struct {
        drng_req_t  req;
        bit         chk_first;
        drng_word_t first_word;
    } stim_row_t;

    logic clk;
    logic rst_n;
    cdrng_in_if  in_req();
    cdrng_out_if out_rsp();

    chacha20_drng_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_req  (in_req.sink),
        .out_rsp (out_rsp.source)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Predictor state: mirrors the generator's key, counter, nonce, seed ptr.
    // ---------------------------------------------------------------------
    word_t       key_q[KEY_WORDS];
    word_t       blk_ctr;
    word_t       nonce_q[3];
    logic [5:0]  seed_pos;
    word_t       ks_block[BLOCK_WORDS];
    drng_word_t  expected_words[$];
    int          error_count;
    int          cycle_count;
    bit          drain_phase;    // no idling in the last part of the run
    bit          hold_sink;      // long receiver hold-off

    function automatic word_t rotl(word_t x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // ChaCha20 block of the current state; bumps the block counter.
    task automatic chacha_block(output word_t dst[BLOCK_WORDS]);
        word_t s[BLOCK_WORDS];
        word_t x[BLOCK_WORDS];
        int    qi[8][4];
        qi = '{'{0, 4, 8, 12}, '{1, 5, 9, 13}, '{2, 6, 10, 14}, '{3, 7, 11, 15},
               '{0, 5, 10, 15}, '{1, 6, 11, 12}, '{2, 7, 8, 13}, '{3, 4, 9, 14}};
        s[0] = SIGMA0; s[1] = SIGMA1; s[2] = SIGMA2; s[3] = SIGMA3;
        for (int i = 0; i < KEY_WORDS; i++)
            s[4 + i] = key_q[i];
        s[12] = blk_ctr;
        s[13] = nonce_q[0];
        s[14] = nonce_q[1];
        s[15] = nonce_q[2];
        x = s;
        for (int r = 0; r < 10; r++)
        begin
            for (int q = 0; q < 8; q++)
            begin
                int a, b, c, d;
                a = qi[q][0]; b = qi[q][1]; c = qi[q][2]; d = qi[q][3];
                x[a] += x[b]; x[d] = rotl(x[d] ^ x[a], 16);
                x[c] += x[d]; x[b] = rotl(x[b] ^ x[c], 12);
                x[a] += x[b]; x[d] = rotl(x[d] ^ x[a], 8);
                x[c] += x[d]; x[b] = rotl(x[b] ^ x[c], 7);
            end
        end
        for (int i = 0; i < BLOCK_WORDS; i++)
            dst[i] = x[i] + s[i];
        blk_ctr = blk_ctr + 32'd1;
    endtask

    task automatic fold_key(input word_t src[BLOCK_WORDS], input int base);
        for (int i = 0; i < KEY_WORDS; i++)
            key_q[i] ^= src[base + i];
        nonce_q[0] = nonce_q[0] + 32'd1;
        if (nonce_q[0] == 32'd0)
        begin
            nonce_q[1] = nonce_q[1] + 32'd1;
            if (nonce_q[1] == 32'd0)
                nonce_q[2] = nonce_q[2] + 32'd1;
        end
    endtask

    task automatic fold_fresh_block();
        word_t fresh[BLOCK_WORDS];
        chacha_block(fresh);
        fold_key(fresh, 0);
    endtask

    // Advance the predictor by one accepted request and queue its words.
    task automatic predict_request(input drng_req_t r);
        int          n;
        int          nwords;
        int          used;
        int          p;
        drng_word_t  w;
        if (r.operation == 1'b0)
        begin
            p = seed_pos[4:0];
            key_q[p >> 2] ^= word_t'(r.seed_byte) << ((p & 3) * 8);
            p++;
            if (p >= 32 || r.seed_last)
            begin
                fold_fresh_block();
                p = 0;
            end
            seed_pos = 6'(p);
            return;
        end
        n = (r.byte_count > BLOCK_BYTES) ? 64 : int'(r.byte_count);
        if (n > 0)
        begin
            chacha_block(ks_block);
            nwords = (n + 7) / 8;
            for (int k = 0; k < nwords; k++)
            begin
                int v;
                v = n - 8 * k;
                if (v > 8)
                    v = 8;
                w.random_word = {ks_block[2 * k + 1], ks_block[2 * k]};
                if (v < 8)
                    w.random_word &= (64'd1 << (8 * v)) - 64'd1;
                w.valid_bytes = 4'(v);
                w.block_done  = (k + 1 == nwords);
                expected_words.push_back(w);
            end
        end
        if (r.request_last)
        begin
            used = (n == 0) ? BLOCK_WORDS : (n + 3) / 4;
            if (used > KEY_WORDS)
                fold_fresh_block();
            else
                fold_key(ks_block, used);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch @%0d: %s got %h want %h", cycle_count, what, got, want);
        error_count++;
    endtask

    // ---------------------------------------------------------------------
    // Result side: random stalls, one long hold-off, field-by-field check.
    // ---------------------------------------------------------------------
    initial
    begin
        int stall;
        out_rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
                out_rsp.ready <= 1'b0;
            else if (!drain_phase && $urandom_range(0, 9) == 0)
            begin
                stall = $urandom_range(1, 13);
                out_rsp.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
                @(negedge clk);
                out_rsp.ready <= 1'b1;
            end
            else
                out_rsp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        drng_word_t want;
        if (rst_n && out_rsp.valid && out_rsp.ready)
        begin
            if (expected_words.size() == 0)
            begin
                report_mismatch("unexpected word", out_rsp.random_word, 64'd0);
            end
            else
            begin
                want = expected_words.pop_front();
                if (out_rsp.random_word !== want.random_word)
                    report_mismatch("random_word", out_rsp.random_word, want.random_word);
                if (out_rsp.valid_bytes !== want.valid_bytes)
                    report_mismatch("valid_bytes", 64'(out_rsp.valid_bytes),
                                    64'(want.valid_bytes));
                if (out_rsp.block_done !== want.block_done)
                    report_mismatch("block_done", 64'(out_rsp.block_done),
                                    64'(want.block_done));
            end
        end
    end

    // Watchdog: generous cycle limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Request side.
    // ---------------------------------------------------------------------
    task automatic send_request(input drng_req_t r);
        int gap;
        if (!drain_phase && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_req.valid        <= 1'b1;
        in_req.operation    <= r.operation;
        in_req.seed_byte    <= r.seed_byte;
        in_req.seed_last    <= r.seed_last;
        in_req.byte_count   <= r.byte_count;
        in_req.request_last <= r.request_last;
        @(posedge clk);
        while (!in_req.ready)
            @(posedge clk);
        predict_request(r);
        @(negedge clk);
    endtask

    function automatic drng_req_t seed_req(logic [7:0] b, logic last_b);
        drng_req_t r;
        r = '0;
        r.operation = 1'b0;
        r.seed_byte = b;
        r.seed_last = last_b;
        r.byte_count = 7'($urandom);
        r.request_last = 1'($urandom);
        return r;
    endfunction

    function automatic drng_req_t gen_req(logic [6:0] n, logic last_b);
        drng_req_t r;
        r = '0;
        r.operation = 1'b1;
        r.byte_count = n;
        r.request_last = last_b;
        r.seed_byte = 8'($urandom);
        r.seed_last = 1'($urandom);
        return r;
    endfunction

    stim_row_t directed_rows[$];

    initial
    begin
        drng_req_t r;
        int        sent;
        int        nblk;
        int        slen;
        drng_word_t first_gold;

        rst_n = 1'b0;
        clk = 1'b0;
        cycle_count = 0;
        error_count = 0;
        drain_phase = 1'b0;
        hold_sink = 1'b0;
        in_req.valid = 1'b0;
        in_req.operation = 1'b0;
        in_req.seed_byte = 8'h00;
        in_req.seed_last = 1'b0;
        in_req.byte_count = 7'd0;
        in_req.request_last = 1'b0;
        for (int i = 0; i < KEY_WORDS; i++)
            key_q[i] = '0;
        nonce_q = '{default: '0};
        blk_ctr = '0;
        seed_pos = '0;

        // First block after reset: all-zero key, counter and nonce.
        first_gold.random_word = {32'h903df1a0, 32'hade0b876};
        first_gold.valid_bytes = 4'd8;
        first_gold.block_done  = 1'b0;

        // Directed table: extremes of byte_count, saturation, zero-length ends,
        // short non-last blocks, seed byte extremes, ignored field noise.
        directed_rows.push_back('{gen_req(7'd64, 1'b0), 1'b1, first_gold});
        directed_rows.push_back('{gen_req(7'd1, 1'b0), 1'b0, first_gold});
        directed_rows.push_back('{gen_req(7'd127, 1'b1), 1'b0, first_gold});
        directed_rows.push_back('{gen_req(7'd65, 1'b0), 1'b0, first_gold});
        directed_rows.push_back('{gen_req(7'd0, 1'b0), 1'b0, first_gold});
        directed_rows.push_back('{gen_req(7'd0, 1'b1), 1'b0, first_gold});
        directed_rows.push_back('{gen_req(7'd64, 1'b1), 1'b0, first_gold});
        directed_rows.push_back('{gen_req(7'd32, 1'b1), 1'b0, first_gold});
        directed_rows.push_back('{gen_req(7'd31, 1'b1), 1'b0, first_gold});
        directed_rows.push_back('{gen_req(7'd33, 1'b1), 1'b0, first_gold});
        directed_rows.push_back('{gen_req(7'd7, 1'b1), 1'b0, first_gold});
        directed_rows.push_back('{seed_req(8'hff, 1'b0), 1'b0, first_gold});
        directed_rows.push_back('{seed_req(8'h00, 1'b0), 1'b0, first_gold});
        directed_rows.push_back('{seed_req(8'h5a, 1'b1), 1'b0, first_gold});
        directed_rows.push_back('{gen_req(7'd9, 1'b1), 1'b0, first_gold});
        directed_rows.push_back('{seed_req(8'ha5, 1'b1), 1'b0, first_gold});
        directed_rows.push_back('{gen_req(7'd8, 1'b0), 1'b0, first_gold});
        directed_rows.push_back('{gen_req(7'd16, 1'b1), 1'b0, first_gold});

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].req);
            // first request: replace predicted head with the hand-typed word
            if (directed_rows[i].chk_first)
                expected_words[0] = directed_rows[i].first_word;
        end

        // A full 32-byte seed so the block-boundary update is hit too.
        for (int i = 0; i < 32; i++)
            send_request(seed_req(8'($urandom), 1'b0));

        // Long receiver hold-off while requests keep coming.
        hold_sink = 1'b1;
        fork
            begin
                repeat (300) @(negedge clk);
                hold_sink = 1'b0;
            end
            for (int i = 0; i < 6; i++)
                send_request(gen_req(7'd64, i == 5));
        join

        // Random part: well-formed seed strings and generate requests,
        // with some noise items mixed in.
        sent = 0;
        while (sent < 400)
        begin
            if (sent > 330)
                drain_phase = 1'b1;
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    slen = $urandom_range(1, 40);
                    for (int i = 0; i < slen; i++)
                        send_request(seed_req(8'($urandom), i == slen - 1));
                    sent += slen;
                end
                3:
                begin
                    r = '0;
                    r = drng_req_t'($bits(drng_req_t)'($urandom));
                    send_request(r);
                    sent++;
                end
                default:
                begin
                    nblk = $urandom_range(1, 4);
                    for (int b = 0; b < nblk; b++)
                    begin
                        if (b < nblk - 1)
                            send_request(gen_req(7'd64, 1'b0));
                        else
                            send_request(gen_req(7'($urandom_range(0, 70)), 1'b1));
                    end
                    sent += nblk;
                end
            endcase
        end
        in_req.valid <= 1'b0;

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
